FILE: rtl/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Shared types and constants for the points-of-interest record parser.
// ----------------------------------------------------------------------------
package poi_pkg;

    localparam int unsigned MAX_SIZE_W = 20;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 20'd100000;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_RECORD_SIZE = 1'b0;

    // record type bytes
    localparam logic [7:0] TYPE_DELETED      = 8'd0;
    localparam logic [7:0] TYPE_DELETED_ALT  = 8'd100;
    localparam logic [7:0] TYPE_BLOCK_HEADER = 8'd1;
    localparam logic [7:0] TYPE_WAYPOINT     = 8'd2;
    localparam logic [7:0] TYPE_WAYPOINT_ID  = 8'd3;
    localparam logic [7:0] TYPE_SKIP_A       = 8'd8;
    localparam logic [7:0] TYPE_SKIP_B       = 8'd9;
    localparam logic [7:0] TYPE_SKIP_C       = 8'd24;
    localparam logic [7:0] TYPE_SKIP_D       = 8'd25;

    localparam logic [MAX_SIZE_W-1:0] BLOCK_HEADER_LEN = 20'd20;
    localparam logic [32:0]           DELETED_HDR_LEN  = 33'd5;
    localparam logic [31:0]           WAYPOINT_HDR_LEN = 32'd13;
    localparam logic [8:0]            SKIP_HDR_LEN     = 9'd6;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_TEXT      = 3'd1,
        KIND_UNKNOWN   = 3'd2,
        KIND_BAD_SIZE  = 3'd3,
        KIND_TRUNCATED = 3'd4
    } t_kind;

    typedef enum logic [7:0] {
        PH_TYPE     = 8'b0000_0001,
        PH_DEL_SIZE = 8'b0000_0010,
        PH_WPT_SIZE = 8'b0000_0100,
        PH_WPT_LON  = 8'b0000_1000,
        PH_WPT_LAT  = 8'b0001_0000,
        PH_DESC     = 8'b0010_0000,
        PH_LEN      = 8'b0100_0000,
        PH_SKIP     = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_kind                 kind;
        logic [31:0]           longitude;
        logic [31:0]           latitude;
        logic [MAX_SIZE_W-1:0] description_length;
        logic                  extra_id_dropped;
        logic [7:0]            record_kind_byte;
        logic [7:0]            text_byte;
        logic                  last_of_text;
    } t_result;

endpackage

FILE: rtl/poi_cfg.sv
// ----------------------------------------------------------------------------
// poi_cfg
// APB register file holding the largest accepted record size.
// ----------------------------------------------------------------------------
module poi_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [poi_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [poi_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [poi_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [poi_pkg::MAX_SIZE_W-1:0]    o_max_record_size
);
    import poi_pkg::*;

    logic [MAX_SIZE_W-1:0] r_max_size;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_RECORD_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (wr_en) begin
            r_max_size <= pwdata[MAX_SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_RECORD_SIZE) begin
            prdata = {{(CFG_DATA_W-MAX_SIZE_W){1'b0}}, r_max_size};
        end
    end

    assign o_max_record_size = r_max_size;

endmodule

FILE: rtl/poi_parse.sv
// ----------------------------------------------------------------------------
// poi_parse
// Input register and record state machine; one file byte per cycle unless a held result waits.
// ----------------------------------------------------------------------------
module poi_parse (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_file_byte,
    input  logic                            i_final_byte,
    input  logic [poi_pkg::MAX_SIZE_W-1:0]  i_max_record_size,
    input  logic                            i_res_take,
    output logic                            o_fire,
    output logic                            o_res_valid,
    output poi_pkg::t_result                o_res
);
    import poi_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_fin;

    t_phase                r_phase,    n_phase;
    logic [1:0]            r_count,    n_count;
    logic [7:0]            r_type,     n_type;
    logic [31:0]           r_shift,    n_shift;
    logic [31:0]           r_lon,      n_lon;
    logic [MAX_SIZE_W-1:0] r_size,     n_size;
    logic [MAX_SIZE_W-1:0] r_rem,      n_rem;
    logic                  r_halted,   n_halted;

    logic                  fire;
    logic                  bad;
    logic [31:0]           sh_next;
    logic [32:0]           del_len;
    logic [8:0]            skip_len;
    logic [MAX_SIZE_W-1:0] rem_dec;
    logic [MAX_SIZE_W-1:0] desc_len;

    assign fire       = r_in_valid && i_res_take;
    assign o_in_ready = !r_in_valid || i_res_take;
    assign o_fire     = fire;

    assign sh_next  = {r_in_byte, r_shift[31:8]};
    assign del_len  = {sh_next[31], sh_next} - DELETED_HDR_LEN;
    assign skip_len = {1'b0, r_in_byte} + SKIP_HDR_LEN;
    assign rem_dec  = r_rem - MAX_SIZE_W'(1);
    assign desc_len = r_size - WAYPOINT_HDR_LEN[MAX_SIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_file_byte;
            r_in_fin  <= i_final_byte;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_type      = r_type;
        n_shift     = r_shift;
        n_lon       = r_lon;
        n_size      = r_size;
        n_rem       = r_rem;
        n_halted    = r_halted;
        bad         = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!r_halted) begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_type  = r_in_byte;
                    n_count = '0;
                    n_shift = '0;
                    if (r_in_byte == TYPE_DELETED || r_in_byte == TYPE_DELETED_ALT) begin
                        n_phase = PH_DEL_SIZE;
                    end else if (r_in_byte == TYPE_BLOCK_HEADER) begin
                        n_phase = PH_SKIP;
                        n_rem   = BLOCK_HEADER_LEN;
                    end else if (r_in_byte == TYPE_WAYPOINT
                                 || r_in_byte == TYPE_WAYPOINT_ID) begin
                        n_phase = PH_WPT_SIZE;
                    end else if (r_in_byte == TYPE_SKIP_A || r_in_byte == TYPE_SKIP_B
                                 || r_in_byte == TYPE_SKIP_C
                                 || r_in_byte == TYPE_SKIP_D) begin
                        n_phase = PH_LEN;
                    end else begin
                        o_res_valid            = 1'b1;
                        o_res.kind             = KIND_UNKNOWN;
                        o_res.record_kind_byte = r_in_byte;
                    end
                end
                PH_DEL_SIZE, PH_WPT_SIZE, PH_WPT_LON, PH_WPT_LAT: begin
                    n_shift = sh_next;
                    n_count = r_count + 2'd1;
                    // fourth byte completes the little-endian word
                    if (r_count == 2'd3) begin
                        if (r_phase == PH_DEL_SIZE) begin
                            if (del_len[32]
                                || del_len > {13'b0, i_max_record_size}) begin
                                bad = 1'b1;
                            end else begin
                                n_rem   = del_len[MAX_SIZE_W-1:0];
                                n_phase = (del_len == '0) ? PH_TYPE : PH_SKIP;
                            end
                        end else if (r_phase == PH_WPT_SIZE) begin
                            if (sh_next[31] || sh_next < WAYPOINT_HDR_LEN
                                || sh_next > {12'b0, i_max_record_size}) begin
                                bad = 1'b1;
                            end else begin
                                n_size  = sh_next[MAX_SIZE_W-1:0];
                                n_phase = PH_WPT_LON;
                            end
                        end else if (r_phase == PH_WPT_LON) begin
                            n_lon   = sh_next;
                            n_phase = PH_WPT_LAT;
                        end else begin
                            n_rem                    = desc_len;
                            o_res_valid              = 1'b1;
                            o_res.kind               = KIND_HEADER;
                            o_res.longitude          = r_lon;
                            o_res.latitude           = sh_next;
                            o_res.description_length = desc_len;
                            o_res.extra_id_dropped   = (r_type == TYPE_WAYPOINT_ID);
                            n_phase = (desc_len == '0) ? PH_TYPE : PH_DESC;
                        end
                    end
                end
                PH_DESC: begin
                    n_rem              = rem_dec;
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_TEXT;
                    o_res.text_byte    = r_in_byte;
                    o_res.last_of_text = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_LEN: begin
                    if ({11'b0, skip_len} > i_max_record_size) begin
                        bad = 1'b1;
                    end else begin
                        n_rem   = {11'b0, skip_len};
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_TYPE;
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase

            if (bad) begin
                n_halted    = 1'b1;
                o_res_valid = 1'b1;
                o_res       = '0;
                o_res.kind  = KIND_BAD_SIZE;
            end else if (r_in_fin && n_phase != PH_TYPE) begin
                // file ended inside a record
                o_res_valid = 1'b1;
                o_res       = '0;
                o_res.kind  = KIND_TRUNCATED;
                n_phase     = PH_TYPE;
                n_count     = '0;
                n_rem       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_count  <= '0;
            r_type   <= '0;
            r_shift  <= '0;
            r_lon    <= '0;
            r_size   <= '0;
            r_rem    <= '0;
            r_halted <= 1'b0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_type   <= n_type;
            r_shift  <= n_shift;
            r_lon    <= n_lon;
            r_size   <= n_size;
            r_rem    <= n_rem;
            r_halted <= n_halted;
        end
    end

endmodule

FILE: rtl/poi_out.sv
// ----------------------------------------------------------------------------
// poi_out
// Result register between the parser and the output channel.
// ----------------------------------------------------------------------------
module poi_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_res_valid,
    input  poi_pkg::t_result  i_res,
    output logic              o_res_take,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output poi_pkg::t_result  o_res
);
    import poi_pkg::*;

    logic    r_valid;
    t_result r_res;

    // a held request blocks the parser only until the consumer takes it
    assign o_res_take = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= i_res_valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

FILE: rtl/poi_record_stream_parser.sv
// ----------------------------------------------------------------------------
// poi_record_stream_parser
// Splits a points-of-interest byte stream into waypoint headers, description
// bytes and warnings, with an APB register for the largest record size.
// ----------------------------------------------------------------------------
// each byte is held in the input register and its result in the result register
// throughput: one byte per cycle unless output stalls; both registers hold one request
// all record state is computed combinationally from the input register
// reset: synchronous active-low; clears the parser state and the halt flag,
// and sets the size limit to 100000
module poi_record_stream_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [poi_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [poi_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [poi_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_file_byte,
    input  logic                            i_final_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_kind,
    output logic signed [31:0]              o_longitude,
    output logic signed [31:0]              o_latitude,
    output logic [19:0]                     o_description_length,
    output logic                            o_extra_id_dropped,
    output logic [7:0]                      o_record_kind_byte,
    output logic [7:0]                      o_text_byte,
    output logic                            o_last_of_text
);
    import poi_pkg::*;

    logic [MAX_SIZE_W-1:0] max_size;
    logic                  res_take;
    logic                  fire;
    logic                  res_valid;
    t_result               parse_res;
    t_result               out_res;

    poi_cfg u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_max_record_size (max_size)
    );

    poi_parse u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_file_byte       (i_file_byte),
        .i_final_byte      (i_final_byte),
        .i_max_record_size (max_size),
        .i_res_take        (res_take),
        .o_fire            (fire),
        .o_res_valid       (res_valid),
        .o_res             (parse_res)
    );

    poi_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (parse_res),
        .o_res_take  (res_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_kind               = out_res.kind;
    assign o_longitude          = $signed(out_res.longitude);
    assign o_latitude           = $signed(out_res.latitude);
    assign o_description_length = out_res.description_length;
    assign o_extra_id_dropped   = out_res.extra_id_dropped;
    assign o_record_kind_byte   = out_res.record_kind_byte;
    assign o_text_byte          = out_res.text_byte;
    assign o_last_of_text       = out_res.last_of_text;

endmodule
